// File: design/pswg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_pkg
// Shared widths, codes, types and small tables of the stroke vertex generator.
// ----------------------------------------------------------------------------
package pswg_pkg;

	localparam int COORD_W      = 18;
	localparam int OUT_W        = 20;
	localparam int RAD_W        = 19;
	localparam int MUL_W        = 20;
	localparam int PROD_W       = 40;
	localparam int ACC_W        = 42;
	localparam int SQ_IN_W      = 38;
	localparam int ROOT_W       = 19;
	localparam int CORD_W       = 42;
	localparam int ANG_W        = 34;
	localparam int CORD_STEPS   = 30;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 168;

	localparam int FRAC_BITS_DEF        = 16;
	localparam int HALF_WIDTH_SHIFT_DEF = 7;

	localparam logic [1:0] MODE_MOVE    = 2'd0;
	localparam logic [1:0] MODE_LINE    = 2'd1;
	localparam logic [1:0] MODE_PREVIEW = 2'd2;

	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_ARC    = 2'd2;

	localparam logic [2:0] CORNER_LAST = 3'd5;

	localparam logic [2:0] DST_NONE  = 3'd0;
	localparam logic [2:0] DST_LEN2  = 3'd1;
	localparam logic [2:0] DST_LA2   = 3'd2;
	localparam logic [2:0] DST_DOT   = 3'd3;
	localparam logic [2:0] DST_CROSS = 3'd4;
	localparam logic [2:0] DST_AREA  = 3'd5;

	localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef struct packed {
		logic                    vld;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
		logic                    clr;
		logic                    neg;
		logic [2:0]              dst;
	} mac_op_t;

	typedef struct packed {
		logic                    wr;
		logic [2:0]              dst;
		logic signed [ACC_W-1:0] acc;
	} mac_res_t;

	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		case (i)
			5'd0:  r = 34'sd843314856;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043836;
			5'd3:  r = 34'sd133525158;
			5'd4:  r = 34'sd67021686;
			5'd5:  r = 34'sd33543515;
			5'd6:  r = 34'sd16775850;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194282;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			5'd24: r = 34'sd63;
			5'd25: r = 34'sd31;
			5'd26: r = 34'sd15;
			5'd27: r = 34'sd7;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] sat_s20(input logic signed [47:0] v);
		logic [OUT_W-1:0] r;
		if (v > 48'sd524287)
			r = 20'h7ffff;
		else if (v < -48'sd524288)
			r = 20'h80000;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

	function automatic logic [RAD_W-1:0] sat_u19(input logic signed [47:0] v);
		logic [RAD_W-1:0] r;
		if (v < 48'sd0)
			r = '0;
		else if (v > 48'sd524287)
			r = 19'h7ffff;
		else
			r = v[RAD_W-1:0];
		return r;
	endfunction

	// corners 2, 4 and 5 sit at the segment end
	function automatic logic corner_at_end(input logic [2:0] c);
		return (c == 3'd2) || (c == 3'd4) || (c == 3'd5);
	endfunction

	// 1 where the cap offset is +1.0
	function automatic logic off_pos_x(input logic [2:0] c);
		return (c == 3'd2) || (c == 3'd3) || (c == 3'd4);
	endfunction

	function automatic logic off_pos_y(input logic [2:0] c);
		return (c == 3'd1) || (c == 3'd2) || (c == 3'd3);
	endfunction

endpackage

// File: design/pswg_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_mac
// Shared signed multiplier with accumulator; the product is registered, then added into the accumulator register.
// ----------------------------------------------------------------------------
module pswg_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  pswg_pkg::mac_op_t  op,
	output pswg_pkg::mac_res_t res
);
	import pswg_pkg::*;

	logic                     vld_s1;
	logic                     clr_s1;
	logic                     neg_s1;
	logic [2:0]               dst_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;
	logic                     wr_q;
	logic [2:0]               dst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op.a * op.b;
		clr_s1  <= op.clr;
		neg_s1  <= op.neg;
		dst_s1  <= op.dst;
	end

	assign term = neg_s1 ? -ACC_W'(prod_s1) : ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
		end else begin
			wr_q <= vld_s1 && (dst_s1 != DST_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + term;
			dst_q <= dst_s1;
		end
	end

	assign res.wr  = wr_q;
	assign res.dst = dst_q;
	assign res.acc = acc_q;

endmodule

// File: design/pswg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_isqrt
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pswg_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pswg_pkg::SQ_IN_W-1:0]  value,
	output logic                          done,
	output logic [pswg_pkg::ROOT_W-1:0]   root
);
	import pswg_pkg::*;

	localparam int REM_W = ROOT_W + 4;

	logic [SQ_IN_W-1:0] val_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   trial;
	logic [ROOT_W-1:0]  root_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	assign rem_sh = {rem_q[REM_W-3:0], val_q[SQ_IN_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[SQ_IN_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: design/pswg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pswg_div #(
	parameter int NW = 34,
	parameter int DW = 26
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CNT_W = $clog2(NW);

	logic [NW-1:0]    n_q;
	logic [NW-1:0]    q_q;
	logic [DW-1:0]    d_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	assign rem_sh  = {rem_q, n_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sub[DW-1:0];
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

// File: design/pswg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_cordic
// Vectoring cordic, one rotation per cycle; angle of (x, y >= 0) in Q30.
// ----------------------------------------------------------------------------
module pswg_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pswg_pkg::CORD_W-1:0] x_in,
	input  logic signed [pswg_pkg::CORD_W-1:0] y_in,
	output logic                               done,
	output logic signed [pswg_pkg::ANG_W-1:0]  z_out
);
	import pswg_pkg::*;

	logic signed [CORD_W-1:0] x_q;
	logic signed [CORD_W-1:0] y_q;
	logic signed [CORD_W-1:0] xs;
	logic signed [CORD_W-1:0] ys;
	logic signed [ANG_W-1:0]  z_q;
	logic signed [ANG_W-1:0]  at;
	logic [4:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = atan_q30(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(CORD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// left half plane: pre-rotate by a quarter turn
			if (x_in < 0) begin
				x_q <= y_in;
				y_q <= -x_in;
				z_q <= HALF_PI_Q30;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	always_comb begin
		if (z_q < 0)
			z_out = '0;
		else if (z_q > PI_Q30)
			z_out = PI_Q30;
		else
			z_out = z_q;
	end

	assign done = done_q;

endmodule

// File: design/polyline_stroke_vertex_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_stroke_vertex_generator_core
// Expands path points into line quad, cap and joint arc vertices.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_axis   | in  | tvalid / tready     | tuser mode, tdata in_x, in_y
//  m_axis   | out | tvalid / tready     | tuser kind, tlast last, tdata vertex
//  cfg      | in  | cfg_valid/cfg_ready | cfg_data obtuse_arc
//
// a move only latches its point; a line takes a square root of its length, then
// runs the bit-serial divider twice for the normal before its first output word,
// then 12 output words; a preview adds 9 multiplier passes, a second root,
// a cordic angle and 6 more words.
// reset clears the path points and the register; no memory, no clearing pass.
// s_axis_tready is low while an item is in work; a stalled m_axis holds the
// vertex sequence and the block returns to ready once its last word is loaded.
// ----------------------------------------------------------------------------
module polyline_stroke_vertex_generator_core #(
	parameter int FRAC_BITS        = pswg_pkg::FRAC_BITS_DEF,
	parameter int HALF_WIDTH_SHIFT = pswg_pkg::HALF_WIDTH_SHIFT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pswg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // in_x, in_y, pad
	input  logic [1:0]                         s_axis_tuser,  // mode
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// corner, pos_x, pos_y, aux_x, aux_y, center_x, center_y, angle, radius, pad
	output logic [pswg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [1:0]                         m_axis_tuser,  // kind
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [0:0]                         cfg_data       // obtuse_arc
);
	import pswg_pkg::*;

	localparam int NW = COORD_W + FRAC_BITS;
	localparam int DW = ROOT_W + HALF_WIDTH_SHIFT;

	localparam logic signed [47:0] ONE_V   = 48'sd1 <<< FRAC_BITS;
	localparam logic signed [47:0] CAP_RAD = 48'sd1 <<< (FRAC_BITS - 5);
	localparam logic signed [ANG_W-1:0] ANG_RND = 34'sd1 <<< (29 - FRAC_BITS);
	localparam logic [63:0] TWO_PI_RAW = 64'(PI_Q30) * 64'd2 + (64'd1 << (29 - FRAC_BITS));
	localparam logic signed [ANG_W-1:0] TWO_PI_FRAC = ANG_W'(TWO_PI_RAW >> (30 - FRAC_BITS));

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_MWAIT = 4'd2;
	localparam logic [3:0] ST_LEN   = 4'd3;
	localparam logic [3:0] ST_LENW  = 4'd4;
	localparam logic [3:0] ST_DIVX  = 4'd5;
	localparam logic [3:0] ST_DIVXW = 4'd6;
	localparam logic [3:0] ST_DIVY  = 4'd7;
	localparam logic [3:0] ST_DIVYW = 4'd8;
	localparam logic [3:0] ST_SQA   = 4'd9;
	localparam logic [3:0] ST_SQAW  = 4'd10;
	localparam logic [3:0] ST_COR   = 4'd11;
	localparam logic [3:0] ST_CORW  = 4'd12;
	localparam logic [3:0] ST_EMIT  = 4'd13;

	logic [3:0] state_q;

	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, arc_x_q, arc_y_q;
	logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q, px_q, py_q;
	logic [1:0]                mode_q;
	logic                      obtuse_q;

	logic signed [COORD_W:0] vx, vy, ax, ay, nax, dpex, sum_sp, sum_se, sum_pe;
	logic [COORD_W-1:0]      mag_vx, mag_vy;
	logic                    len_zero, la_zero;

	logic [3:0]  job_q;
	logic [3:0]  job_last;
	logic [2:0]  dst_final;
	mac_op_t     mac_op;
	mac_res_t    mac_res;

	logic [SQ_IN_W-1:0]      len2_q, la2_q;
	logic signed [ACC_W-1:0] dot_q, cross_q;
	logic signed [ACC_W-1:0] mag_cross;
	logic                    area_neg_q;

	logic                sq_start, sq_done;
	logic [SQ_IN_W-1:0]  sq_value;
	logic [ROOT_W-1:0]   sq_root;
	logic [ROOT_W-1:0]   len_q, arc_rad_q;

	logic                div_start, div_done;
	logic [NW-1:0]       div_dividend, div_quot;
	logic [DW-1:0]       div_divisor;
	logic signed [NW:0]  nx_q, ny_q, n_div;

	logic                    cor_start, cor_done;
	logic signed [ANG_W-1:0] cor_z, ang_r, ang_o, ang_f;
	logic [OUT_W-1:0]        angle_q;

	logic [1:0] seg_q;
	logic [2:0] corner_q;
	logic [1:0] seg_last;
	logic       in_fire;

	logic signed [47:0] v_px, v_py, v_ax, v_ay, v_cx, v_cy, v_rad;
	logic [OUT_W-1:0]   v_ang;
	logic               v_last;

	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [1:0]             m_user_q;
	logic                   m_last_q;
	logic                   m_valid_q;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// segment and arc operands, all from the latched points
	assign vx     = (COORD_W + 1)'(ex_q) - (COORD_W + 1)'(sx_q);
	assign vy     = (COORD_W + 1)'(ey_q) - (COORD_W + 1)'(sy_q);
	assign ax     = (COORD_W + 1)'(px_q) - (COORD_W + 1)'(sx_q);
	assign ay     = (COORD_W + 1)'(py_q) - (COORD_W + 1)'(sy_q);
	assign nax    = -ax;
	assign dpex   = (COORD_W + 1)'(px_q) - (COORD_W + 1)'(ex_q);
	assign sum_sp = (COORD_W + 1)'(sy_q) + (COORD_W + 1)'(py_q);
	assign sum_se = (COORD_W + 1)'(ey_q) + (COORD_W + 1)'(sy_q);
	assign sum_pe = (COORD_W + 1)'(py_q) + (COORD_W + 1)'(ey_q);

	assign mag_vx   = vx[COORD_W] ? COORD_W'(-vx) : vx[COORD_W-1:0];
	assign mag_vy   = vy[COORD_W] ? COORD_W'(-vy) : vy[COORD_W-1:0];
	assign len_zero = (vx == '0) && (vy == '0);
	assign la_zero  = (ax == '0) && (ay == '0);

	assign job_last  = (mode_q == MODE_LINE) ? 4'd1 : 4'd10;
	assign dst_final = (mode_q == MODE_LINE) ? DST_LEN2 : DST_AREA;
	assign seg_last  = (mode_q == MODE_LINE) ? KIND_CIRCLE : KIND_ARC;

	always_comb begin
		mac_op     = '0;
		mac_op.vld = (state_q == ST_MUL);
		case (job_q)
			4'd0: begin
				mac_op.a = MUL_W'(vx); mac_op.b = MUL_W'(vx); mac_op.clr = 1'b1;
			end
			4'd1: begin
				mac_op.a = MUL_W'(vy); mac_op.b = MUL_W'(vy); mac_op.dst = DST_LEN2;
			end
			4'd2: begin
				mac_op.a = MUL_W'(ax); mac_op.b = MUL_W'(ax); mac_op.clr = 1'b1;
			end
			4'd3: begin
				mac_op.a = MUL_W'(ay); mac_op.b = MUL_W'(ay); mac_op.dst = DST_LA2;
			end
			4'd4: begin
				mac_op.a = MUL_W'(ax); mac_op.b = MUL_W'(vx); mac_op.clr = 1'b1;
			end
			4'd5: begin
				mac_op.a = MUL_W'(ay); mac_op.b = MUL_W'(vy); mac_op.dst = DST_DOT;
			end
			4'd6: begin
				mac_op.a = MUL_W'(ax); mac_op.b = MUL_W'(vy); mac_op.clr = 1'b1;
			end
			4'd7: begin
				mac_op.a = MUL_W'(ay); mac_op.b = MUL_W'(vx); mac_op.neg = 1'b1;
				mac_op.dst = DST_CROSS;
			end
			// winding sum over the three joint points
			4'd8: begin
				mac_op.a = MUL_W'(nax); mac_op.b = MUL_W'(sum_sp); mac_op.clr = 1'b1;
			end
			4'd9: begin
				mac_op.a = MUL_W'(vx); mac_op.b = MUL_W'(sum_se);
			end
			4'd10: begin
				mac_op.a = MUL_W'(dpex); mac_op.b = MUL_W'(sum_pe); mac_op.dst = DST_AREA;
			end
			default: begin
				mac_op.vld = 1'b0;
			end
		endcase
	end

	pswg_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.res    (mac_res)
	);

	assign sq_start = (state_q == ST_LEN) || (state_q == ST_SQA);
	assign sq_value = (state_q == ST_LEN) ? len2_q : la2_q;

	pswg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (sq_value),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign div_start    = (state_q == ST_DIVX) || (state_q == ST_DIVY);
	assign div_dividend = (state_q == ST_DIVX) ? {mag_vx, {FRAC_BITS{1'b0}}}
	                                           : {mag_vy, {FRAC_BITS{1'b0}}};
	assign div_divisor  = {len_q, {HALF_WIDTH_SHIFT{1'b0}}};

	pswg_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign mag_cross = cross_q[ACC_W-1] ? -cross_q : cross_q;
	assign cor_start = (state_q == ST_COR);

	pswg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x_in   (dot_q),
		.y_in   (mag_cross),
		.done   (cor_done),
		.z_out  (cor_z)
	);

	// divide result takes the sign of the component being divided
	always_comb begin
		n_div = $signed({1'b0, div_quot});
		if (state_q == ST_DIVXW ? vx[COORD_W] : vy[COORD_W])
			n_div = -n_div;
	end

	assign ang_r = (cor_z + ANG_RND) >>> (30 - FRAC_BITS);
	assign ang_o = obtuse_q ? ang_r - TWO_PI_FRAC : ang_r;
	assign ang_f = area_neg_q ? -ang_o : ang_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obtuse_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			arc_x_q  <= '0;
			arc_y_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				obtuse_q <= cfg_data[0];
			if (in_fire && (s_axis_tuser == MODE_MOVE || s_axis_tuser == MODE_LINE)) begin
				arc_x_q <= cur_x_q;
				arc_y_q <= cur_y_q;
				cur_x_q <= s_axis_tdata[COORD_W-1:0];
				cur_y_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sx_q   <= cur_x_q;
			sy_q   <= cur_y_q;
			px_q   <= arc_x_q;
			py_q   <= arc_y_q;
			ex_q   <= s_axis_tdata[COORD_W-1:0];
			ey_q   <= s_axis_tdata[2*COORD_W-1:COORD_W];
			mode_q <= s_axis_tuser;
		end
		if (mac_res.wr) begin
			case (mac_res.dst)
				DST_LEN2:  len2_q     <= mac_res.acc[SQ_IN_W-1:0];
				DST_LA2:   la2_q      <= mac_res.acc[SQ_IN_W-1:0];
				DST_DOT:   dot_q      <= mac_res.acc;
				DST_CROSS: cross_q    <= mac_res.acc;
				DST_AREA:  area_neg_q <= mac_res.acc[ACC_W-1];
				default: ;
			endcase
		end
		if (state_q == ST_LENW && sq_done) begin
			len_q <= sq_root;
			nx_q  <= '0;
			ny_q  <= '0;
		end
		if (state_q == ST_DIVXW && div_done)
			nx_q <= n_div;
		if (state_q == ST_DIVYW && div_done)
			ny_q <= n_div;
		if (state_q == ST_SQAW && sq_done) begin
			arc_rad_q <= sq_root;
			angle_q   <= '0;
		end
		if (state_q == ST_CORW && cor_done)
			angle_q <= sat_s20(48'(ang_f));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			job_q    <= '0;
			seg_q    <= KIND_LINE;
			corner_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					job_q    <= '0;
					seg_q    <= KIND_LINE;
					corner_q <= '0;
					if (in_fire && (s_axis_tuser == MODE_LINE || s_axis_tuser == MODE_PREVIEW))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					job_q <= job_q + 4'd1;
					if (job_q == job_last)
						state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mac_res.wr && mac_res.dst == dst_final)
						state_q <= ST_LEN;
				end
				ST_LEN:  state_q <= ST_LENW;
				ST_LENW: begin
					if (sq_done) begin
						if (len_zero)
							state_q <= (mode_q == MODE_LINE) ? ST_EMIT : ST_SQA;
						else
							state_q <= ST_DIVX;
					end
				end
				ST_DIVX:  state_q <= ST_DIVXW;
				ST_DIVXW: if (div_done) state_q <= ST_DIVY;
				ST_DIVY:  state_q <= ST_DIVYW;
				ST_DIVYW: begin
					if (div_done)
						state_q <= (mode_q == MODE_LINE) ? ST_EMIT : ST_SQA;
				end
				ST_SQA:  state_q <= ST_SQAW;
				ST_SQAW: begin
					if (sq_done)
						state_q <= (la_zero || len_zero) ? ST_EMIT : ST_COR;
				end
				ST_COR:  state_q <= ST_CORW;
				ST_CORW: if (cor_done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!m_valid_q || m_axis_tready) begin
						if (corner_q == CORNER_LAST) begin
							corner_q <= '0;
							seg_q    <= 2'(seg_q + 2'd1);
							if (seg_q == seg_last)
								state_q <= ST_IDLE;
						end else begin
							corner_q <= corner_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// vertex fields for the current output slot
	always_comb begin
		v_px   = '0;
		v_py   = '0;
		v_ax   = '0;
		v_ay   = '0;
		v_cx   = '0;
		v_cy   = '0;
		v_ang  = '0;
		v_rad  = '0;
		v_last = 1'b0;
		case (seg_q)
			KIND_LINE: begin
				v_px = corner_at_end(corner_q) ? 48'(ex_q) : 48'(sx_q);
				v_py = corner_at_end(corner_q) ? 48'(ey_q) : 48'(sy_q);
				v_ax = corner_q[0] ? -48'(ny_q) : 48'(ny_q);
				v_ay = corner_q[0] ? 48'(nx_q) : -48'(nx_q);
			end
			KIND_CIRCLE: begin
				v_px   = 48'(ex_q);
				v_py   = 48'(ey_q);
				v_ax   = off_pos_x(corner_q) ? ONE_V : -ONE_V;
				v_ay   = off_pos_y(corner_q) ? ONE_V : -ONE_V;
				v_rad  = CAP_RAD;
				v_last = (mode_q == MODE_LINE) && (corner_q == CORNER_LAST);
			end
			KIND_ARC: begin
				v_px   = 48'(sx_q) + (off_pos_x(corner_q) ? ONE_V : -ONE_V);
				v_py   = 48'(sy_q) + (off_pos_y(corner_q) ? ONE_V : -ONE_V);
				v_ax   = 48'(px_q);
				v_ay   = 48'(py_q);
				v_cx   = 48'(sx_q);
				v_cy   = 48'(sy_q);
				v_ang  = angle_q;
				v_rad  = $signed({29'd0, arc_rad_q});
				v_last = (corner_q == CORNER_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!m_valid_q || m_axis_tready))
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!m_valid_q || m_axis_tready)) begin
			m_user_q <= seg_q;
			m_last_q <= v_last;
			m_data_q <= {6'd0, sat_u19(v_rad), v_ang, sat_s20(v_cy), sat_s20(v_cx),
			             sat_s20(v_ay), sat_s20(v_ax), sat_s20(v_py), sat_s20(v_px),
			             corner_q};
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	a_busy_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_axis_tuser == MODE_LINE || s_axis_tuser == MODE_PREVIEW))
		|=> !s_axis_tready)
		else $error("block ready right after a drawing item");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast)
		|-> (m_axis_tuser == KIND_CIRCLE || m_axis_tuser == KIND_ARC))
		else $error("last word on a line vertex");

	a_mac_window: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res.wr |-> (state_q == ST_MWAIT || state_q == ST_MUL))
		else $error("multiplier result outside the product phase");

	a_angle_arc_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_ARC) |-> (m_axis_tdata[142:123] == '0))
		else $error("nonzero angle on a non-arc vertex");

endmodule

// File: sim/pswg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswg_checker
// Watches the point, vertex and register channels of the stroke vertex
// generator and predicts every vertex from the accepted points. Each accepted
// vertex is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pswg_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [pswg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                       s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [pswg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [1:0]                       m_axis_tuser,
	input  logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [0:0]                       cfg_data,
	output int                               fail_count,
	output int                               pending
);
	import pswg_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int HW = HALF_WIDTH_SHIFT_DEF;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  corner;
		logic [19:0] px, py, ax, ay, cx, cy, ang;
		logic [18:0] rad;
		logic        last;
	} vertex_t;

	vertex_t vertex_q[$];
	longint  cur_x, cur_y, prev_x, prev_y;
	logic    obtuse;

	function automatic logic [19:0] sat20(longint v);
		if (v > 524287) v = 524287;
		if (v < -524288) v = -524288;
		return v[19:0];
	endfunction

	function automatic logic [18:0] satu19(longint v);
		if (v < 0) v = 0;
		if (v > 524287) v = 524287;
		return v[18:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint absval(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint normal_comp(longint c, longint len);
		longint q;
		q = (absval(c) << FB) / (len << HW);
		return (c < 0) ? -q : q;
	endfunction

	function automatic longint atan_tab(int i);
		longint tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
			31, 15, 7, 3, 1};
		return tab[i];
	endfunction

	// cordic atan2 for y >= 0, q30 in [0, pi]
	function automatic longint cordic_angle(longint x, longint y);
		longint z, t, nx, ny;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = HALF_PI_Q30;
		end
		for (int i = 0; i < CORD_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_tab(i);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_tab(i);
			end
			x = nx;
			y = ny;
		end
		if (z < 0) z = 0;
		if (z > PI_Q30) z = PI_Q30;
		return z;
	endfunction

	function automatic longint q30_round(longint z);
		return (z + (64'sd1 << (29 - FB))) >>> (30 - FB);
	endfunction

	function automatic longint off_x(int k);
		return (k >= 2 && k <= 4) ? 1 : -1;
	endfunction

	function automatic longint off_y(int k);
		return (k >= 1 && k <= 3) ? 1 : -1;
	endfunction

	task automatic push_vertex(logic [1:0] kind, int k, longint px, longint py,
			longint ax, longint ay, longint cx, longint cy, longint ang, longint rad,
			logic last);
		vertex_t v;
		v.kind = kind;
		v.corner = k[2:0];
		v.px = sat20(px);
		v.py = sat20(py);
		v.ax = sat20(ax);
		v.ay = sat20(ay);
		v.cx = sat20(cx);
		v.cy = sat20(cy);
		v.ang = sat20(ang);
		v.rad = satu19(rad);
		v.last = last;
		vertex_q.push_back(v);
	endtask

	task automatic predict_segment(longint x1, longint y1, longint x2, longint y2,
			logic cap_last);
		longint vx, vy, nx, ny, len;
		logic at_end;
		vx = x2 - x1;
		vy = y2 - y1;
		nx = 0;
		ny = 0;
		len = root64(vx * vx + vy * vy);
		if (len != 0) begin
			nx = normal_comp(vx, len);
			ny = normal_comp(vy, len);
		end
		for (int k = 0; k < 6; k++) begin
			at_end = (k == 2) || (k == 4) || (k == 5);
			push_vertex(KIND_LINE, k, at_end ? x2 : x1, at_end ? y2 : y1,
				k[0] ? -ny : ny, k[0] ? nx : -nx, 0, 0, 0, 0, 1'b0);
		end
		for (int k = 0; k < 6; k++)
			push_vertex(KIND_CIRCLE, k, x2, y2, off_x(k) << FB, off_y(k) << FB,
				0, 0, 0, 64'sd1 << (FB - 5), cap_last && (k == 5));
	endtask

	task automatic predict_arc(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint ax, ay, bx, by, la2, lb2, d, c, area, ang;
		ax = px - qx;
		ay = py - qy;
		bx = rx - qx;
		by = ry - qy;
		la2 = ax * ax + ay * ay;
		lb2 = bx * bx + by * by;
		ang = 0;
		if (la2 != 0 && lb2 != 0) begin
			d = ax * bx + ay * by;
			c = ax * by - ay * bx;
			area = (qx - px) * (qy + py) + (rx - qx) * (ry + qy) + (px - rx) * (py + ry);
			ang = q30_round(cordic_angle(d, absval(c)));
			if (obtuse) ang = -(q30_round(2 * longint'(PI_Q30)) - ang);
			if (area < 0) ang = -ang;
		end
		for (int k = 0; k < 6; k++)
			push_vertex(KIND_ARC, k, qx + (off_x(k) << FB), qy + (off_y(k) << FB),
				px, py, qx, qy, ang, longint'(root64(la2)), k == 5);
	endtask

	task automatic check_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: vertex %s mismatch, expected %h, got %h", $time, name,
				exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		longint x, y;
		if (!arst_n) begin
			vertex_q.delete();
			cur_x = 0;
			cur_y = 0;
			prev_x = 0;
			prev_y = 0;
			obtuse = 1'b0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (vertex_q.size() == 0) begin
					$display("%0t: unexpected vertex word, expected none, got %h", $time,
						m_axis_tdata);
					fail_count++;
				end else begin
					e = vertex_q.pop_front();
					check_field("kind", 20'(e.kind), 20'(m_axis_tuser));
					check_field("corner", 20'(e.corner), 20'(m_axis_tdata[2:0]));
					check_field("pos_x", e.px, m_axis_tdata[22:3]);
					check_field("pos_y", e.py, m_axis_tdata[42:23]);
					check_field("aux_x", e.ax, m_axis_tdata[62:43]);
					check_field("aux_y", e.ay, m_axis_tdata[82:63]);
					check_field("center_x", e.cx, m_axis_tdata[102:83]);
					check_field("center_y", e.cy, m_axis_tdata[122:103]);
					check_field("angle", e.ang, m_axis_tdata[142:123]);
					check_field("radius", 20'(e.rad), 20'(m_axis_tdata[161:143]));
					check_field("last", 20'(e.last), 20'(m_axis_tlast));
				end
			end
			if (cfg_valid && cfg_ready)
				obtuse = cfg_data[0];
			if (s_axis_tvalid && s_axis_tready) begin
				x = longint'(signed'(s_axis_tdata[17:0]));
				y = longint'(signed'(s_axis_tdata[35:18]));
				case (s_axis_tuser)
					MODE_MOVE: begin
						prev_x = cur_x;
						prev_y = cur_y;
						cur_x = x;
						cur_y = y;
					end
					MODE_LINE: begin
						predict_segment(cur_x, cur_y, x, y, 1'b1);
						prev_x = cur_x;
						prev_y = cur_y;
						cur_x = x;
						cur_y = y;
					end
					MODE_PREVIEW: begin
						predict_segment(cur_x, cur_y, x, y, 1'b0);
						predict_arc(prev_x, prev_y, cur_x, cur_y, x, y);
					end
					default: ;
				endcase
			end
			pending = vertex_q.size();
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives points and register writes into the stroke vertex generator with
// random gaps and back pressure; the checker predicts and compares vertices.
// ----------------------------------------------------------------------------
module tb;
	import pswg_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // in_x, in_y, pad
	logic [1:0]             s_axis_tuser;   // mode
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// corner, pos_x, pos_y, aux_x, aux_y, center_x, center_y, angle, radius, pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;   // kind
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [0:0]             cfg_data;       // obtuse_arc
	int                     fail_count;
	int                     pending;
	logic                   no_idle;
	logic                   hold_req;

	localparam int DRAIN_CYCLES = 300;
	// mode code with no meaning, ignored by the block
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	polyline_stroke_vertex_generator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	pswg_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// vertex receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_point(logic [1:0] mode, logic [17:0] x, logic [17:0] y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {4'd0, y, x};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_obtuse(logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [17:0] rand_coord(int sel);
		int v;
		if (sel == 0)
			v = $urandom;
		else if (sel == 1)
			v = $urandom_range(0, 8) - 4;
		else
			v = $urandom_range(0, 131072) - 65536;
		return v[17:0];
	endfunction

	task automatic random_point();
		int r, sel;
		logic [1:0] mode;
		r = $urandom_range(0, 19);
		if (r == 0) mode = MODE_UNUSED;
		else if (r < 6) mode = MODE_MOVE;
		else if (r < 14) mode = MODE_LINE;
		else mode = MODE_PREVIEW;
		sel = $urandom_range(0, 7);
		send_point(mode, rand_coord(sel), rand_coord(sel));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_MOVE;
		cfg_valid = 1'b0;
		cfg_data = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			write_obtuse(phase[0]);
			no_idle = (phase == 2);
			if (phase == 0) begin
				send_point(MODE_PREVIEW, 18'd0, 18'd0);
				send_point(MODE_MOVE, 18'd0, 18'd0);
				send_point(MODE_LINE, 18'(65536), 18'(65536));
				send_point(MODE_LINE, 18'(-65536), 18'(-65536));
				send_point(MODE_PREVIEW, 18'(65536), 18'(-65536));
				send_point(MODE_PREVIEW, 18'(-65536), 18'(-65536));
				send_point(MODE_LINE, 18'(-65536), 18'(-65536));
				send_point(MODE_PREVIEW, 18'(65536), 18'(65536));
				send_point(MODE_UNUSED, 18'h1ffff, 18'h20000);
				send_point(MODE_MOVE, 18'(-65536), 18'(65536));
				send_point(MODE_LINE, 18'h1ffff, 18'h1ffff);
				send_point(MODE_LINE, 18'h20000, 18'h20000);
				send_point(MODE_PREVIEW, 18'h1ffff, 18'h20000);
				send_point(MODE_MOVE, 18'd0, 18'd0);
				send_point(MODE_MOVE, 18'd100, 18'd0);
				send_point(MODE_PREVIEW, 18'd200, 18'd0);
				send_point(MODE_PREVIEW, 18'd0, 18'd0);
				send_point(MODE_PREVIEW, 18'd100, 18'd100);
				send_point(MODE_PREVIEW, 18'd100, 18'(-100));
				send_point(MODE_LINE, 18'd1, 18'd0);
				send_point(MODE_LINE, 18'd1, 18'd1);
			end
			if (phase == 1)
				hold_req = 1'b1;
			for (int n = 0; n < 68; n++) begin
				if (n == 34)
					wait_idle();
				random_point();
			end
			wait_idle();
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
